// File: rtl/dses_pkg.sv
// Shared widths, constants, stage types and saturation helpers for the stump search.
package dses_pkg;

   localparam int VALUE_PORT_W    = 32;
   localparam int WEIGHT_W        = 31;
   localparam int FEATURE_OUT_W   = 12;
   localparam int SUM_W           = 49;
   localparam int EDGE_W          = 50;

   localparam int DEF_MAX_FEATURES = 4096;
   localparam int DEF_VALUE_BITS   = 32;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [EDGE_W-1:0] EDGE_MAX = {1'b0, {(EDGE_W-1){1'b1}}};
   localparam logic signed [EDGE_W-1:0] EDGE_MIN = {1'b1, {(EDGE_W-1){1'b0}}};
   // -1.0 in Q0.31: the bar every feature has to beat
   localparam logic signed [EDGE_W-1:0] EDGE_MINUS_ONE = EDGE_W'(-64'sd2147483648);

   // snapshot of one finished feature, accumulator to edge stage
   typedef struct packed {
      logic signed [SUM_W-1:0]        total;
      logic signed [SUM_W-1:0]        lbs;
      logic signed [VALUE_PORT_W-1:0] lbv;
      logic signed [SUM_W-1:0]        mus;
      logic signed [VALUE_PORT_W-1:0] muv;
      logic signed [VALUE_PORT_W-1:0] value;
      logic                           end_round;
   } feat_type;

   // best stump of one feature, edge stage to round-best stage
   typedef struct packed {
      logic signed [EDGE_W-1:0]       score;
      logic signed [VALUE_PORT_W-1:0] cut;
      logic                           ge_dir;
      logic                           end_round;
   } cand_type;

   // one spare bit on top never overflows, so the sign bits tell saturation
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
      logic signed [SUM_W-1:0] r;
      if (x[SUM_W] != x[SUM_W-1]) begin
         r = x[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         r = x[SUM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [EDGE_W-1:0] sat_edge(input logic signed [EDGE_W:0] x);
      logic signed [EDGE_W-1:0] r;
      if (x[EDGE_W] != x[EDGE_W-1]) begin
         r = x[EDGE_W] ? EDGE_MIN : EDGE_MAX;
      end else begin
         r = x[EDGE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/decision_stump_edge_search_unit.sv
// Decision stump edge search: top level, configuration register and stage wiring.
//
// Usage: samples of one boosting round stream in on the req_ channel, feature
// after feature, ascending by value within a feature, each with a Q0.31 weight
// and a label. req_last_of_feature closes a feature, req_last_of_round closes
// the round (and its feature). One item leaves on the rsp_ channel per round:
// the best feature index, its cut, its direction and its edge.
// csr_allow_less_equal is written through csr_valid/csr_ready; the user must write
// it only while idle, which the block does not enforce; csr_ready is always high.
// Throughput: one sample per cycle while req_stall is low, set by the running-sum
// update in the accumulator. Path: a round end passes the input register, feature
// snapshot, edge stage and result register before it shows on rsp_valid.
// Stalls: the result register holds while rsp_stall is high; samples keep
// flowing until a second round end waits at the round-best stage and feature
// ends fill the snapshot and input registers behind it, then req_stall rises.
// Reset clears all valids, the round best and the feature counter, and
// sets allow_less_equal to 0; the block accepts items in the first cycle after.
module decision_stump_edge_search_unit #(
   parameter int MAX_FEATURES = dses_pkg::DEF_MAX_FEATURES,
   parameter int VALUE_BITS   = dses_pkg::DEF_VALUE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [dses_pkg::VALUE_PORT_W-1:0]  req_sample_value,
   input  logic [dses_pkg::WEIGHT_W-1:0]             req_sample_weight,
   input  logic                                      req_label_positive,
   input  logic                                      req_last_of_feature,
   input  logic                                      req_last_of_round,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [dses_pkg::FEATURE_OUT_W-1:0]        rsp_best_feature,
   output logic signed [dses_pkg::VALUE_PORT_W-1:0]  rsp_best_cut,
   output logic                                      rsp_greater_equal,
   output logic signed [dses_pkg::EDGE_W-1:0]        rsp_winning_edge,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic                                      csr_allow_less_equal
);
   import dses_pkg::*;

   logic      allow_ff, allow_in;
   logic      feat_valid, feat_ready;
   feat_type  feat;
   logic      cand_valid, cand_ready;
   cand_type  cand;

   assign csr_ready = 1'b1;
   assign allow_in  = (csr_valid && csr_ready) ? csr_allow_less_equal : allow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
      end else begin
         allow_ff <= allow_in;
      end
   end

   dses_accum #(
      .VALUE_BITS (VALUE_BITS)
   ) u_accum (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_sample_weight   (req_sample_weight),
      .req_label_positive  (req_label_positive),
      .req_last_of_feature (req_last_of_feature),
      .req_last_of_round   (req_last_of_round),
      .feat_valid          (feat_valid),
      .feat                (feat),
      .feat_ready          (feat_ready)
   );

   dses_edge u_edge (
      .clock            (clock),
      .reset            (reset),
      .allow_less_equal (allow_ff),
      .feat_valid       (feat_valid),
      .feat             (feat),
      .feat_ready       (feat_ready),
      .cand_valid       (cand_valid),
      .cand             (cand),
      .cand_ready       (cand_ready)
   );

   dses_best #(
      .MAX_FEATURES (MAX_FEATURES)
   ) u_best (
      .clock             (clock),
      .reset             (reset),
      .cand_valid        (cand_valid),
      .cand              (cand),
      .cand_ready        (cand_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_feature  (rsp_best_feature),
      .rsp_best_cut      (rsp_best_cut),
      .rsp_greater_equal (rsp_greater_equal),
      .rsp_winning_edge  (rsp_winning_edge)
   );

endmodule

// File: rtl/dses_accum.sv
// Input register and per-feature running sums with cut candidate tracking.
module dses_accum #(
   parameter int VALUE_BITS = dses_pkg::DEF_VALUE_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [dses_pkg::VALUE_PORT_W-1:0]   req_sample_value,
   input  logic [dses_pkg::WEIGHT_W-1:0]              req_sample_weight,
   input  logic                                       req_label_positive,
   input  logic                                       req_last_of_feature,
   input  logic                                       req_last_of_round,
   output logic                                       feat_valid,
   output dses_pkg::feat_type                         feat,
   input  logic                                       feat_ready
);
   import dses_pkg::*;

   logic                          in_valid_ff, in_valid_in;
   logic signed [VALUE_BITS-1:0]  in_value_ff, in_value_in;
   logic [WEIGHT_W-1:0]           in_weight_ff, in_weight_in;
   logic                          in_label_ff, in_label_in;
   logic                          in_end_feat_ff, in_end_feat_in;
   logic                          in_end_round_ff, in_end_round_in;

   logic                          have_prev_ff, have_prev_in;
   logic signed [VALUE_BITS-1:0]  prev_ff, prev_in;
   logic signed [SUM_W-1:0]       rs_ff, rs_in;
   logic signed [SUM_W-1:0]       lbs_ff, lbs_in;
   logic signed [VALUE_BITS-1:0]  lbv_ff, lbv_in;
   logic signed [SUM_W-1:0]       mus_ff, mus_in;
   logic signed [VALUE_BITS-1:0]  muv_ff, muv_in;

   logic                          feat_valid_ff, feat_valid_in;
   feat_type                      feat_ff, feat_in;

   logic                          accept, feat_free, move;
   logic signed [VALUE_PORT_W-1:0] sw_mag, sw;
   logic signed [SUM_W-1:0]       base, total;
   logic signed [SUM_W-1:0]       lbs_n, mus_n;
   logic signed [VALUE_BITS-1:0]  lbv_n, muv_n;

   assign feat_free = !feat_valid_ff || feat_ready;
   // an item that ends no feature never waits on the downstream stages
   assign move      = in_valid_ff && (!in_end_feat_ff || feat_free);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in     = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      in_value_in     = accept ? req_sample_value[VALUE_BITS-1:0] : in_value_ff;
      in_weight_in    = accept ? req_sample_weight : in_weight_ff;
      in_label_in     = accept ? req_label_positive : in_label_ff;
      in_end_feat_in  = accept ? (req_last_of_feature || req_last_of_round) : in_end_feat_ff;
      in_end_round_in = accept ? req_last_of_round : in_end_round_ff;
   end

   always_comb begin
      sw_mag = VALUE_PORT_W'({1'b0, in_weight_ff});
      sw     = in_label_ff ? sw_mag : -sw_mag;
      lbs_n  = lbs_ff;
      lbv_n  = lbv_ff;
      mus_n  = mus_ff;
      muv_n  = muv_ff;
      base   = rs_ff;
      if (!have_prev_ff) begin
         base  = '0;
         lbs_n = '0;
         lbv_n = in_value_ff;
         mus_n = SUM_MIN;
         muv_n = in_value_ff;
      end else if (in_value_ff != prev_ff) begin
         // sum so far is the weight strictly below the new value
         if (rs_ff < lbs_ff) begin
            lbs_n = rs_ff;
            lbv_n = in_value_ff;
         end
         if (rs_ff >= mus_ff) begin
            mus_n = rs_ff;
            muv_n = prev_ff;
         end
      end
      total = sat_sum((SUM_W+1)'(base) + (SUM_W+1)'(sw));
   end

   always_comb begin
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      rs_in        = rs_ff;
      lbs_in       = lbs_ff;
      lbv_in       = lbv_ff;
      mus_in       = mus_ff;
      muv_in       = muv_ff;
      if (move) begin
         have_prev_in = !in_end_feat_ff;
         prev_in      = in_value_ff;
         rs_in        = in_end_feat_ff ? '0 : total;
         lbs_in       = lbs_n;
         lbv_in       = lbv_n;
         mus_in       = mus_n;
         muv_in       = muv_n;
      end
   end

   always_comb begin
      feat_in       = feat_ff;
      feat_valid_in = feat_ready ? 1'b0 : feat_valid_ff;
      if (move && in_end_feat_ff) begin
         feat_valid_in     = 1'b1;
         feat_in.total     = total;
         feat_in.lbs       = lbs_n;
         feat_in.lbv       = VALUE_PORT_W'(lbv_n);
         feat_in.mus       = mus_n;
         feat_in.muv       = VALUE_PORT_W'(muv_n);
         feat_in.value     = VALUE_PORT_W'(in_value_ff);
         feat_in.end_round = in_end_round_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         have_prev_ff  <= 1'b0;
         feat_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         have_prev_ff  <= have_prev_in;
         feat_valid_ff <= feat_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_value_ff     <= in_value_in;
      in_weight_ff    <= in_weight_in;
      in_label_ff     <= in_label_in;
      in_end_feat_ff  <= in_end_feat_in;
      in_end_round_ff <= in_end_round_in;
      prev_ff         <= prev_in;
      rs_ff           <= rs_in;
      lbs_ff          <= lbs_in;
      lbv_ff          <= lbv_in;
      mus_ff          <= mus_in;
      muv_ff          <= muv_in;
      feat_ff         <= feat_in;
   end

   assign feat_valid = feat_valid_ff;
   assign feat       = feat_ff;

endmodule

// File: rtl/dses_edge.sv
// Edge stage: ge and le edges of one feature; le is picked only if allowed and better.
module dses_edge (
   input  logic                clock,
   input  logic                reset,
   input  logic                allow_less_equal,
   input  logic                feat_valid,
   input  dses_pkg::feat_type  feat,
   output logic                feat_ready,
   output logic                cand_valid,
   output dses_pkg::cand_type  cand,
   input  logic                cand_ready
);
   import dses_pkg::*;

   logic                            cand_valid_ff, cand_valid_in;
   cand_type                        cand_ff, cand_in;

   logic signed [EDGE_W:0]          total_x, ge_raw, le_alt, le_raw;
   logic signed [EDGE_W-1:0]        ge_score, le_score;
   logic signed [VALUE_PORT_W-1:0]  le_cut;
   logic                            up_total, take;

   assign feat_ready = !cand_valid_ff || cand_ready;
   assign take       = feat_valid && feat_ready;

   always_comb begin
      total_x  = (EDGE_W+1)'(feat.total);
      ge_raw   = total_x - (EDGE_W+1)'($signed({feat.lbs, 1'b0}));
      ge_score = sat_edge(ge_raw);
      // the whole feature counts as the final at-or-below candidate
      up_total = feat.total >= feat.mus;
      le_alt   = (EDGE_W+1)'($signed({feat.mus, 1'b0})) - total_x;
      le_raw   = up_total ? total_x : le_alt;
      le_score = sat_edge(le_raw);
      le_cut   = up_total ? feat.value : feat.muv;
   end

   always_comb begin
      cand_in       = cand_ff;
      cand_valid_in = cand_ready ? 1'b0 : cand_valid_ff;
      if (take) begin
         cand_valid_in     = 1'b1;
         cand_in.end_round = feat.end_round;
         if (allow_less_equal && (le_score > ge_score)) begin
            cand_in.score  = le_score;
            cand_in.cut    = le_cut;
            cand_in.ge_dir = 1'b0;
         end else begin
            cand_in.score  = ge_score;
            cand_in.cut    = feat.lbv;
            cand_in.ge_dir = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   assign cand_valid = cand_valid_ff;
   assign cand       = cand_ff;

endmodule

// File: rtl/dses_best.sv
// Round-best stage: feature counter, best stump of the round and the result register.
module dses_best #(
   parameter int MAX_FEATURES = dses_pkg::DEF_MAX_FEATURES
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      cand_valid,
   input  dses_pkg::cand_type                        cand,
   output logic                                      cand_ready,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [dses_pkg::FEATURE_OUT_W-1:0]        rsp_best_feature,
   output logic signed [dses_pkg::VALUE_PORT_W-1:0]  rsp_best_cut,
   output logic                                      rsp_greater_equal,
   output logic signed [dses_pkg::EDGE_W-1:0]        rsp_winning_edge
);
   import dses_pkg::*;

   localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   logic [FEAT_W-1:0]               cnt_ff, cnt_in;
   logic signed [EDGE_W-1:0]        best_edge_ff, best_edge_in;
   logic signed [VALUE_PORT_W-1:0]  best_cut_ff, best_cut_in;
   logic                            best_dir_ff, best_dir_in;
   logic [FEAT_W-1:0]               best_feat_ff, best_feat_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [FEATURE_OUT_W-1:0]        rsp_feature_ff, rsp_feature_in;
   logic signed [VALUE_PORT_W-1:0]  rsp_cut_ff, rsp_cut_in;
   logic                            rsp_dir_ff, rsp_dir_in;
   logic signed [EDGE_W-1:0]        rsp_edge_ff, rsp_edge_in;

   logic                            take, emit, better;
   logic [FEAT_W:0]                 cnt_inc;
   logic [FEAT_W-1:0]               cnt_next;
   logic signed [EDGE_W-1:0]        new_edge;
   logic signed [VALUE_PORT_W-1:0]  new_cut;
   logic                            new_dir;
   logic [FEAT_W-1:0]               new_feat;
   logic [FEAT_W+FEATURE_OUT_W-1:0] feat_ext;

   // only a round end needs the result register to be free
   assign cand_ready = !cand_valid || !cand.end_round || !rsp_valid_ff || !rsp_stall;
   assign take       = cand_valid && cand_ready;
   assign emit       = take && cand.end_round;

   always_comb begin
      cnt_inc  = {1'b0, cnt_ff} + (FEAT_W+1)'(1);
      cnt_next = (cnt_inc >= (FEAT_W+1)'(MAX_FEATURES)) ? '0 : cnt_inc[FEAT_W-1:0];
      better   = cand.score > best_edge_ff;
      new_edge = better ? cand.score  : best_edge_ff;
      new_cut  = better ? cand.cut    : best_cut_ff;
      new_dir  = better ? cand.ge_dir : best_dir_ff;
      new_feat = better ? cnt_ff      : best_feat_ff;
      feat_ext = {{FEATURE_OUT_W{1'b0}}, new_feat};
   end

   always_comb begin
      cnt_in       = cnt_ff;
      best_edge_in = best_edge_ff;
      best_cut_in  = best_cut_ff;
      best_dir_in  = best_dir_ff;
      best_feat_in = best_feat_ff;
      if (emit) begin
         cnt_in       = '0;
         best_edge_in = EDGE_MINUS_ONE;
         best_cut_in  = '0;
         best_dir_in  = 1'b1;
         best_feat_in = '0;
      end else if (take) begin
         cnt_in       = cnt_next;
         best_edge_in = new_edge;
         best_cut_in  = new_cut;
         best_dir_in  = new_dir;
         best_feat_in = new_feat;
      end
   end

   always_comb begin
      rsp_valid_in   = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_feature_in = emit ? feat_ext[FEATURE_OUT_W-1:0] : rsp_feature_ff;
      rsp_cut_in     = emit ? new_cut  : rsp_cut_ff;
      rsp_dir_in     = emit ? new_dir  : rsp_dir_ff;
      rsp_edge_in    = emit ? new_edge : rsp_edge_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         best_edge_ff <= EDGE_MINUS_ONE;
         best_cut_ff  <= '0;
         best_dir_ff  <= 1'b1;
         best_feat_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         best_edge_ff <= best_edge_in;
         best_cut_ff  <= best_cut_in;
         best_dir_ff  <= best_dir_in;
         best_feat_ff <= best_feat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_feature_ff <= rsp_feature_in;
      rsp_cut_ff     <= rsp_cut_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_edge_ff    <= rsp_edge_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_feature  = rsp_feature_ff;
   assign rsp_best_cut      = rsp_cut_ff;
   assign rsp_greater_equal = rsp_dir_ff;
   assign rsp_winning_edge  = rsp_edge_ff;

endmodule

// File: rtl/dses_checker.sv
// Port-level assertions for the stump search top level, with its bind.
module dses_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_stall,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic [dses_pkg::FEATURE_OUT_W-1:0]        rsp_best_feature,
   input  logic signed [dses_pkg::VALUE_PORT_W-1:0]  rsp_best_cut,
   input  logic                                      rsp_greater_equal,
   input  logic signed [dses_pkg::EDGE_W-1:0]        rsp_winning_edge
);
   import dses_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_winning_edge)
         && $stable(rsp_best_cut) && $stable(rsp_best_feature) && $stable(rsp_greater_equal))
      else $error("result changed while stalled");

   // samples only back up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // the round bar starts at -1.0 and only rises
   a_edge_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_winning_edge >= EDGE_MINUS_ONE)
      else $error("winning edge below -1.0");

   // nothing beat the bar: the round-start stump comes out
   a_empty_round: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_winning_edge == EDGE_MINUS_ONE)
         |-> (rsp_best_feature == '0) && (rsp_best_cut == '0) && rsp_greater_equal)
      else $error("default stump fields wrong");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("activity straight after reset");

endmodule

bind decision_stump_edge_search_unit dses_checker u_dses_checker (.*);

// File: test/tb_decision_stump_edge_search_unit.sv
// Self-checking testbench for the decision stump edge search unit.
`timescale 1ns / 1ps

module tb_decision_stump_edge_search_unit;

   import dses_pkg::*;

   localparam int  MAX_GAP      = 8;
   localparam int  CSR_SETTLE   = 10;    // pipeline is four stages deep
   localparam int  DRAIN_END    = 40;
   localparam int  LONG_HOLD    = 600;
   localparam int  HOLD_ROUND_A = 10;
   localparam int  HOLD_ROUND_B = 40;
   localparam int  RANDOM_ITEMS = 880;

   localparam longint SUM_HI    = longint'(SUM_MAX);
   localparam longint SUM_LO    = longint'(SUM_MIN);
   localparam longint EDGE_HI   = longint'(EDGE_MAX);
   localparam longint EDGE_LO   = longint'(EDGE_MIN);
   localparam longint MINUS_ONE = longint'(EDGE_MINUS_ONE);

   localparam logic signed [VALUE_PORT_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_PORT_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic [WEIGHT_W-1:0]            WEIGHT_MAX = 31'h7FFF_FFFF;

   typedef enum logic {ENTRY_SAMPLE, ENTRY_CSR} entry_kind_type;

   typedef struct packed {
      entry_kind_type                 kind;
      logic signed [VALUE_PORT_W-1:0] value;
      logic [WEIGHT_W-1:0]            weight;
      logic                           positive;
      logic                           last_feature;
      logic                           last_round;
      logic                           allow_le;
   } entry_type;

   typedef struct packed {
      logic [FEATURE_OUT_W-1:0]       feature;
      logic signed [VALUE_PORT_W-1:0] cut;
      logic                           ge;
      logic signed [EDGE_W-1:0]       score;
   } stump_type;

   logic clock;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [VALUE_PORT_W-1:0] req_sample_value = '0;
   logic [WEIGHT_W-1:0]            req_sample_weight = '0;
   logic                           req_label_positive = 1'b0;
   logic                           req_last_of_feature = 1'b0;
   logic                           req_last_of_round = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [FEATURE_OUT_W-1:0]       rsp_best_feature;
   logic signed [VALUE_PORT_W-1:0] rsp_best_cut;
   logic                           rsp_greater_equal;
   logic signed [EDGE_W-1:0]       rsp_winning_edge;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic                           csr_allow_less_equal = 1'b0;

   entry_type pending_samples[$];
   stump_type expected_stumps[$];

   // predictor state
   longint prev_value, run_sum, below_sum, below_cut, upto_sum, upto_cut;
   longint best_score, best_cut;
   bit     have_prev, best_ge, le_enabled;
   int     best_feature, feat_count;

   int     errors = 0;
   longint cycles = 0;
   longint cycle_limit = 64'd50_000_000;
   int     items_in = 0;
   int     rounds_in = 0;
   int     results_seen = 0;
   int     csr_writes = 0;
   int     input_stall_cycles = 0;
   int     hold_left = 0;
   int     holds_done = 0;

   decision_stump_edge_search_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_value     (req_sample_value),
      .req_sample_weight    (req_sample_weight),
      .req_label_positive   (req_label_positive),
      .req_last_of_feature  (req_last_of_feature),
      .req_last_of_round    (req_last_of_round),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_best_feature     (rsp_best_feature),
      .rsp_best_cut         (rsp_best_cut),
      .rsp_greater_equal    (rsp_greater_equal),
      .rsp_winning_edge     (rsp_winning_edge),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_allow_less_equal (csr_allow_less_equal)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // one accepted sample through the stump search; queues a result at round end
   function automatic void stump_search_step(input entry_type s);
      longint    v, w, sw, total, score, le_score, cut;
      bit        ge, end_feature;
      stump_type r;
      v  = longint'(s.value);
      w  = longint'({33'd0, s.weight});
      sw = s.positive ? w : -w;
      end_feature = s.last_feature || s.last_round;
      if (!have_prev) begin
         run_sum   = 0;
         below_sum = 0;
         below_cut = v;
         upto_sum  = SUM_LO;
         upto_cut  = v;
         have_prev = 1'b1;
      end else if (v != prev_value) begin
         // a change of value opens a new candidate cut, sorted or not
         if (run_sum < below_sum) begin
            below_sum = run_sum;
            below_cut = v;
         end
         if (run_sum >= upto_sum) begin
            upto_sum = run_sum;
            upto_cut = prev_value;
         end
      end
      run_sum    = clamp_to(run_sum + sw, SUM_LO, SUM_HI);
      prev_value = v;

      if (end_feature) begin
         total = run_sum;
         if (total >= upto_sum) begin
            upto_sum = total;
            upto_cut = v;
         end
         score = clamp_to(total - 2 * below_sum, EDGE_LO, EDGE_HI);
         cut   = below_cut;
         ge    = 1'b1;
         if (le_enabled) begin
            le_score = clamp_to(2 * upto_sum - total, EDGE_LO, EDGE_HI);
            if (le_score > score) begin
               score = le_score;
               cut   = upto_cut;
               ge    = 1'b0;
            end
         end
         if (score > best_score) begin
            best_score   = score;
            best_cut     = cut;
            best_ge      = ge;
            best_feature = feat_count;
         end
         feat_count = (feat_count + 1 >= DEF_MAX_FEATURES) ? 0 : feat_count + 1;
         have_prev  = 1'b0;
         run_sum    = 0;
      end

      if (s.last_round) begin
         r.feature = best_feature[FEATURE_OUT_W-1:0];
         r.cut     = best_cut[VALUE_PORT_W-1:0];
         r.ge      = best_ge;
         r.score   = best_score[EDGE_W-1:0];
         expected_stumps.insert(expected_stumps.size(), r);
         best_score   = MINUS_ONE;
         best_cut     = 0;
         best_ge      = 1'b1;
         best_feature = 0;
         feat_count   = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH cycle %0d: %s", cycles, msg);
   endtask

   task automatic push_sample(input logic signed [VALUE_PORT_W-1:0] v,
                              input logic [WEIGHT_W-1:0] w, input logic pos,
                              input logic eof, input logic eor);
      entry_type e;
      e.kind         = ENTRY_SAMPLE;
      e.value        = v;
      e.weight       = w;
      e.positive     = pos;
      e.last_feature = eof;
      e.last_round   = eor;
      e.allow_le     = 1'b0;
      pending_samples.insert(pending_samples.size(), e);
   endtask

   task automatic push_csr(input logic le);
      entry_type e;
      e          = '0;
      e.kind     = ENTRY_CSR;
      e.allow_le = le;
      pending_samples.insert(pending_samples.size(), e);
   endtask

   // a feature of random content, mostly ascending with ties, now and then unsorted
   task automatic push_feature(input int len, input bit closes_round);
      longint              v;
      bit                  shuffled, last;
      logic [WEIGHT_W-1:0] w;
      shuffled = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
         0:       v = longint'(VALUE_MIN);
         1:       v = longint'(VALUE_MAX) - $urandom_range(0, 50);
         default: v = longint'($signed($urandom()));
      endcase
      for (int i = 0; i < len; i++) begin
         if (i != 0) begin
            if (shuffled) begin
               v = longint'($signed($urandom()));
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2: v = v;
                  3, 4:    v = v + longint'($urandom_range(0, 32'h7FFF_FFFF));
                  default: v = v + longint'($urandom_range(1, 1000));
               endcase
               if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
            end
         end
         case ($urandom_range(0, 9))
            0:       w = WEIGHT_MAX;
            1:       w = '0;
            2, 3:    w = WEIGHT_W'($urandom_range(1, 1000));
            default: w = WEIGHT_W'($urandom());
         endcase
         last = (i == len - 1);
         push_sample(v[VALUE_PORT_W-1:0], w, 1'($urandom_range(0, 1)),
                     last && !(closes_round && $urandom_range(0, 3) == 0),
                     last && closes_round);
      end
   endtask

   // sender: bursts of items with random gaps; register writes only once drained
   always @(posedge clock) begin : driver
      entry_type on_port;
      int        burst_left, gap_left, quiet;
      logic      fire;
      if (reset) begin
         req_valid  <= 1'b0;
         csr_valid  <= 1'b0;
         burst_left = $urandom_range(1, 64);
         gap_left   = 0;
         quiet      = 0;
         have_prev  = 1'b0;
         prev_value = 0;
         run_sum    = 0;
         below_sum  = 0;
         below_cut  = 0;
         upto_sum   = 0;
         upto_cut   = 0;
         le_enabled = 1'b0;
         best_score   = MINUS_ONE;
         best_cut     = 0;
         best_ge      = 1'b1;
         best_feature = 0;
         feat_count   = 0;
      end else begin
         fire = req_valid && !req_stall;
         if (req_valid && req_stall) input_stall_cycles++;
         if (fire) begin
            stump_search_step(on_port);
            items_in++;
            if (on_port.last_round) rounds_in <= rounds_in + 1;
         end
         if (fire || req_valid) quiet = 0;
         else if (quiet < 1000) quiet++;

         if (!req_valid || fire) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0
                         && pending_samples[0].kind == ENTRY_SAMPLE) begin
               on_port = pending_samples.pop_front();
               req_sample_value    <= on_port.value;
               req_sample_weight   <= on_port.weight;
               req_label_positive  <= on_port.positive;
               req_last_of_feature <= on_port.last_feature;
               req_last_of_round   <= on_port.last_round;
               req_valid           <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 64);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (csr_valid) begin
            if (csr_ready) begin
               le_enabled = csr_allow_less_equal;
               csr_writes++;
               csr_valid <= 1'b0;
               void'(pending_samples.pop_front());
            end
         end else if (!req_valid && pending_samples.size() != 0
                      && pending_samples[0].kind == ENTRY_CSR
                      && expected_stumps.size() == 0 && quiet >= CSR_SETTLE) begin
            csr_valid            <= 1'b1;
            csr_allow_less_equal <= pending_samples[0].allow_le;
         end
      end
   end

   // long receiver hold-offs so that round ends pile up and the input backs up
   always @(posedge clock) begin : holdoff
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2
                   && rounds_in >= ((holds_done == 0) ? HOLD_ROUND_A : HOLD_ROUND_B)) begin
         hold_left  <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   // receiver: checks each result item, stalls on a pattern that changes over time
   always @(posedge clock) begin : monitor
      stump_type want;
      logic      stall_now;
      int        stall_mode, mode_left, phase_count;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  = 0;
         mode_left   = 0;
         phase_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stumps.size() == 0) begin
               report_mismatch($sformatf("result item with none expected (feature %0d)",
                                         rsp_best_feature));
            end else begin
               want = expected_stumps.pop_front();
               if (rsp_best_feature !== want.feature)
                  report_mismatch($sformatf("result %0d best_feature %0d, want %0d",
                                            results_seen, rsp_best_feature, want.feature));
               if (rsp_best_cut !== want.cut)
                  report_mismatch($sformatf("result %0d best_cut %0d, want %0d",
                                            results_seen, rsp_best_cut, want.cut));
               if (rsp_greater_equal !== want.ge)
                  report_mismatch($sformatf("result %0d greater_equal %0b, want %0b",
                                            results_seen, rsp_greater_equal, want.ge));
               if (rsp_winning_edge !== want.score)
                  report_mismatch($sformatf("result %0d winning_edge %0d, want %0d",
                                            results_seen, rsp_winning_edge, want.score));
            end
            results_seen++;
         end

         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         phase_count++;
         case (stall_mode)
            0:       stall_now = 1'b0;
            1:       stall_now = ($urandom_range(0, 9) < 4);
            default: stall_now = ((phase_count % 7) < 3);
         endcase
         rsp_stall <= stall_now || (hold_left > 1);
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles > cycle_limit) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycles, expected_stumps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int added, nfeat, len;

      // directed, register at its reset value: extremes, ties, round end alone
      push_sample(VALUE_MIN, WEIGHT_MAX, 1'b1, 1'b0, 1'b0);
      push_sample(VALUE_MIN, '0, 1'b0, 1'b0, 1'b0);
      push_sample(32'sd0, WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
      push_sample(VALUE_MAX, 31'd1, 1'b1, 1'b1, 1'b0);
      push_sample(32'sd5, '0, 1'b0, 1'b0, 1'b1);
      // nothing beats -1.0
      push_sample(32'sd3, WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
      push_sample(32'sd3, WEIGHT_MAX, 1'b0, 1'b0, 1'b1);
      // unsorted values, feature and round flags together
      push_sample(32'sd10, 31'd500, 1'b0, 1'b0, 1'b0);
      push_sample(32'sd3, 31'd700, 1'b1, 1'b0, 1'b0);
      push_sample(32'sd3, 31'd200, 1'b0, 1'b0, 1'b0);
      push_sample(32'sd7, 31'd900, 1'b1, 1'b0, 1'b0);
      push_sample(-32'sd2, 31'd100, 1'b0, 1'b1, 1'b1);
      // equal edges across features: the earlier one stands
      push_sample(32'sd1, 31'd100, 1'b1, 1'b1, 1'b0);
      push_sample(32'sd2, 31'd100, 1'b1, 1'b1, 1'b1);

      push_csr(1'b1);
      // le equal to ge stays ge
      push_sample(32'sd4, 31'd50, 1'b1, 1'b1, 1'b1);
      // le wins, and on a tie takes the larger cut
      push_sample(32'sd1, 31'd100, 1'b1, 1'b0, 1'b0);
      push_sample(32'sd2, 31'd100, 1'b0, 1'b0, 1'b0);
      push_sample(32'sd3, 31'd100, 1'b1, 1'b0, 1'b0);
      push_sample(32'sd4, 31'd100, 1'b0, 1'b1, 1'b1);
      push_sample(32'sd1, 31'd1000, 1'b1, 1'b0, 1'b0);
      push_sample(32'sd2, 31'd1000, 1'b0, 1'b1, 1'b1);

      // random rounds, register toggled between phases
      for (int p = 0; p < 6; p++) begin
         push_csr(p[0]);
         added = 0;
         while (added < RANDOM_ITEMS / 6) begin
            nfeat = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
            for (int f = 0; f < nfeat; f++) begin
               case ($urandom_range(0, 19))
                  0:             len = $urandom_range(21, 40);
                  1, 2, 3, 4, 5: len = $urandom_range(7, 20);
                  default:       len = $urandom_range(1, 6);
               endcase
               push_feature(len, f == nfeat - 1);
               added += len;
            end
         end
      end

      cycle_limit = 100_000 + longint'(pending_samples.size()) * (MAX_GAP + 12)
                    + 4 * LONG_HOLD;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || csr_valid
             || expected_stumps.size() != 0);
      repeat (DRAIN_END) @(posedge clock);

      $display("%0d samples in %0d rounds, %0d results checked, %0d register writes",
               items_in, rounds_in, results_seen, csr_writes);
      $display("input held back on %0d cycles; ties, unsorted values, empty rounds, %s",
               input_stall_cycles, "lone round ends, both directions");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/dses_pkg.sv
rtl/dses_accum.sv
rtl/dses_edge.sv
rtl/dses_best.sv
rtl/decision_stump_edge_search_unit.sv
rtl/dses_checker.sv
test/tb_decision_stump_edge_search_unit.sv
